FILE: rtl/buffer_pool_oldest_replacement_unit_macros.svh
// assertion macros for the buffer pool oldest replacement unit
// expects clk and rst (synchronous, active high) in the module that uses them
`ifndef BUFFER_POOL_OLDEST_REPLACEMENT_UNIT_MACROS_SVH
`define BUFFER_POOL_OLDEST_REPLACEMENT_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define BPOR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define BPOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpor_pkg.sv
// shared types, codes and constants of the buffer pool oldest replacement unit
// no dependencies
package bpor_pkg;

  // default sizes
  localparam int SLOT_COUNT_DEF       = 32;
  localparam int DISK_BLOCK_COUNT_DEF = 8192;

  // fixed field widths
  localparam int REQ_W      = 2;
  localparam int BLOCK_IN_W = 16;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 5;
  localparam int WB_BLOCK_W = 13;

  // slot age, saturating
  localparam int               AGE_W   = 5;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DIRTY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_BUF   = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_LOOKUP,
    OP_MARK,
    OP_REPLY
  } op_t;

  // command handed from front to back
  typedef struct packed {
    op_t                   op;
    logic [STATUS_W-1:0]   status;
    logic [BLOCK_IN_W-1:0] block;
  } cmd_t;

endpackage

FILE: rtl/bpor_front.sv
// front end: accepts request items, checks the bound and decodes the type
// depends on bpor_pkg
module bpor_front #(
  parameter int DISK_BLOCK_COUNT = bpor_pkg::DISK_BLOCK_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bpor_pkg::REQ_W-1:0]         req_type,
  input  logic [bpor_pkg::BLOCK_IN_W-1:0]    block_num,
  output logic                               push_valid,
  input  logic                               push_stall,
  output bpor_pkg::cmd_t                     push_cmd
);
  import bpor_pkg::*;

  localparam int CMP_W = BLOCK_IN_W + 1;

  logic cmd_valid;
  cmd_t cmd;
  cmd_t cmd_next;
  logic out_of_bound;

  // classify the incoming item
  always_comb begin
    out_of_bound      = {1'b0, block_num} >= CMP_W'(DISK_BLOCK_COUNT);
    cmd_next.block    = block_num;
    cmd_next.status   = ST_OK;
    cmd_next.op       = OP_REPLY;
    if (out_of_bound) begin
      cmd_next.status = ST_OUT_OF_BOUND;
    end else begin
      case (req_type)
        REQ_ALLOC:  cmd_next.op = OP_ALLOC;
        REQ_LOOKUP: cmd_next.op = OP_LOOKUP;
        REQ_DIRTY:  cmd_next.op = OP_MARK;
        default:    cmd_next.status = ST_NOT_IN_BUF;
      endcase
    end
  end

  assign in_stall   = cmd_valid && push_stall;
  assign push_valid = cmd_valid;
  assign push_cmd   = cmd;

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      cmd_valid <= 1'b1;
    end else if (!push_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: rtl/bpor_queue.sv
// short command queue that decouples the front end from the scan engine
// depends on bpor_pkg and the assertion macro header
`include "buffer_pool_oldest_replacement_unit_macros.svh"
module bpor_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_stall,
  input  bpor_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_stall,
  output bpor_pkg::cmd_t pop_cmd
);
  import bpor_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_stall = count == CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `BPOR_ASSERT_SAME(a_q_count_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `BPOR_ASSERT_NEXT(a_q_push_only, push && !pop, count == $past(count) + 1'b1, "push lost")
  `BPOR_ASSERT_NEXT(a_q_pop_only, pop && !push, count == $past(count) - 1'b1, "pop lost")

endmodule

FILE: rtl/bpor_back.sv
// back end: scans the slot tables one slot a cycle and carries out commands
// depends on bpor_pkg and the assertion macro header
`include "buffer_pool_oldest_replacement_unit_macros.svh"
module bpor_back #(
  parameter int SLOT_COUNT       = bpor_pkg::SLOT_COUNT_DEF,
  parameter int DISK_BLOCK_COUNT = bpor_pkg::DISK_BLOCK_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  bpor_pkg::cmd_t                   cmd,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpor_pkg::STATUS_W-1:0]    status,
  output logic [bpor_pkg::SLOT_OUT_W-1:0]  slot_index,
  output logic                             writeback_valid,
  output logic [bpor_pkg::WB_BLOCK_W-1:0]  writeback_block
);
  import bpor_pkg::*;

  localparam int IDX_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W     = IDX_W + 1;
  localparam int BLK_W     = $clog2(DISK_BLOCK_COUNT);
  localparam int SLOT_EXT_W = IDX_W + SLOT_OUT_W;
  localparam int WB_EXT_W  = BLK_W + WB_BLOCK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t            state;
  cmd_t              job;
  logic [CNT_W-1:0]  cnt;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [SLOT_COUNT-1:0] occ;
  logic [SLOT_COUNT-1:0] dirty;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [AGE_W-1:0]  best_age;
  logic [IDX_W-1:0]  best_idx;
  logic [BLK_W-1:0]  best_block;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;

  // slot memories
  logic [AGE_W-1:0]  age_mem   [SLOT_COUNT];
  logic [BLK_W-1:0]  block_mem [SLOT_COUNT];
  logic [AGE_W-1:0]  age_q;
  logic [BLK_W-1:0]  block_q;

  logic              issue;
  logic [IDX_W-1:0]  rd_addr;
  logic              slot_occ;
  logic [AGE_W-1:0]  age_inc;
  logic              blk_match;
  logic              fin;
  logic [IDX_W-1:0]  pick;
  logic              evict_dirty;
  logic              age_we;
  logic [IDX_W-1:0]  age_wa;
  logic [AGE_W-1:0]  age_wd;
  logic              block_we;

  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;
  logic                res_wb;
  logic [BLK_W-1:0]    res_wb_block;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic [WB_EXT_W-1:0]   wb_ext;

  // scan read side
  assign issue     = (state == S_SCAN) && (cnt != CNT_W'(SLOT_COUNT));
  assign rd_addr   = cnt[IDX_W-1:0];
  assign slot_occ  = occ[rd_idx];
  assign age_inc   = (age_q == AGE_MAX) ? age_q : age_q + 1'b1;
  assign blk_match = BLOCK_IN_W'(block_q) == job.block;
  assign cmd_stall = state != S_IDLE;

  // commit point and victim choice
  assign fin         = (state == S_FINISH) && !(out_valid && out_stall);
  assign pick        = free_found ? free_idx : best_idx;
  assign evict_dirty = !free_found && dirty[best_idx];

  // memory write ports
  always_comb begin
    age_we   = 1'b0;
    age_wa   = rd_idx;
    age_wd   = age_inc;
    block_we = 1'b0;
    if (fin && job.op == OP_ALLOC) begin
      age_we   = 1'b1;
      age_wa   = pick;
      age_wd   = '0;
      block_we = 1'b1;
    end else if (rd_vld && job.op == OP_ALLOC && slot_occ) begin
      age_we   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
    age_q <= age_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (block_we) begin
      block_mem[pick] <= job.block[BLK_W-1:0];
    end
    block_q <= block_mem[rd_addr];
  end

  // result of the finished command
  always_comb begin
    res_status   = ST_OK;
    res_idx      = '0;
    res_wb       = 1'b0;
    res_wb_block = '0;
    case (job.op)
      OP_REPLY: begin
        res_status = job.status;
      end
      OP_ALLOC: begin
        res_idx = pick;
        res_wb  = evict_dirty;
        if (evict_dirty) begin
          res_wb_block = best_block;
        end
      end
      OP_LOOKUP, OP_MARK: begin
        if (hit_found) begin
          res_idx = hit_idx;
        end else begin
          res_status = ST_NOT_IN_BUF;
        end
      end
      default: begin
        res_status = ST_NOT_IN_BUF;
      end
    endcase
    slot_ext = SLOT_EXT_W'(res_idx);
    wb_ext   = WB_EXT_W'(res_wb_block);
  end

  // sequencer, slot flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      occ        <= '0;
      dirty      <= '0;
      free_found <= 1'b0;
      hit_found  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      rd_vld <= issue;
      if (issue) begin
        cnt    <= cnt + 1'b1;
        rd_idx <= rd_addr;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            job        <= cmd;
            cnt        <= '0;
            free_found <= 1'b0;
            hit_found  <= 1'b0;
            best_age   <= '0;
            best_idx   <= '0;
            state      <= (cmd.op == OP_REPLY) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (job.op == OP_ALLOC) begin
              if (!slot_occ && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= rd_idx;
              end
              if (slot_occ && age_inc >= best_age) begin
                best_age   <= age_inc;
                best_idx   <= rd_idx;
                best_block <= block_q;
              end
            end else if (slot_occ && blk_match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
            end
          end
          if (!issue && !rd_vld) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin) begin
            status          <= res_status;
            slot_index      <= slot_ext[SLOT_OUT_W-1:0];
            writeback_valid <= res_wb;
            writeback_block <= wb_ext[WB_BLOCK_W-1:0];
            if (job.op == OP_ALLOC) begin
              occ[pick]   <= 1'b1;
              dirty[pick] <= 1'b0;
            end else if (job.op == OP_MARK && hit_found) begin
              dirty[hit_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BPOR_ASSERT_SAME(a_b_cnt_bound, 1'b1, cnt <= CNT_W'(SLOT_COUNT), "scan counter overran")
  `BPOR_ASSERT_SAME(a_b_wb_ok, out_valid && writeback_valid, status == ST_OK, "write-back on failure")
  `BPOR_ASSERT_SAME(a_b_fail_zero, out_valid && status != ST_OK, slot_index == '0 && !writeback_valid, "failure result not cleared")
  `BPOR_ASSERT_NEXT(a_b_alloc_occ, fin && job.op == OP_ALLOC, occ[$past(pick)], "allocated slot not occupied")

endmodule

FILE: rtl/buffer_pool_oldest_replacement_unit.sv
// top level of the buffer pool oldest replacement unit
// depends on bpor_pkg, bpor_front, bpor_queue and bpor_back
//
//   channel   direction   handshake            payload
//   in        into block  in_valid / in_stall  req_type, block_num
//   out       out of block out_valid / out_stall status, slot_index,
//                                               writeback_valid, writeback_block
//
// allocate, lookup and mark-dirty each run a full scan of the slot age and block memories,
// which the scan reads one slot a cycle
// out of bound and unused request types do no scan
// reset clears the occupied and dirty flag registers directly; there is no clearing pass
// a waiting result holds in the output register while the next item is taken and scanned
module buffer_pool_oldest_replacement_unit #(
  parameter int SLOT_COUNT       = bpor_pkg::SLOT_COUNT_DEF,
  parameter int DISK_BLOCK_COUNT = bpor_pkg::DISK_BLOCK_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bpor_pkg::REQ_W-1:0]       req_type,
  input  logic [bpor_pkg::BLOCK_IN_W-1:0]  block_num,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpor_pkg::STATUS_W-1:0]    status,
  output logic [bpor_pkg::SLOT_OUT_W-1:0]  slot_index,
  output logic                             writeback_valid,
  output logic [bpor_pkg::WB_BLOCK_W-1:0]  writeback_block
);
  import bpor_pkg::*;

  logic push_valid;
  logic push_stall;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_stall;
  cmd_t pop_cmd;

  // request decode
  bpor_front #(
    .DISK_BLOCK_COUNT(DISK_BLOCK_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .block_num (block_num),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_cmd  (push_cmd)
  );

  // command queue
  bpor_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_cmd   (pop_cmd)
  );

  // slot scan engine
  bpor_back #(
    .SLOT_COUNT      (SLOT_COUNT),
    .DISK_BLOCK_COUNT(DISK_BLOCK_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (pop_valid),
    .cmd_stall      (pop_stall),
    .cmd            (pop_cmd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .slot_index     (slot_index),
    .writeback_valid(writeback_valid),
    .writeback_block(writeback_block)
  );

endmodule

FILE: sim/buffer_pool_oldest_replacement_unit_tb.sv
// self-checking testbench for buffer_pool_oldest_replacement_unit
// uses bpor_pkg for widths and codes; a scoreboard class keeps its own copy of the slot pool
module buffer_pool_oldest_replacement_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpor_pkg::*;

  localparam int SLOTS          = SLOT_COUNT_DEF;
  localparam int BLOCK_LIMIT    = DISK_BLOCK_COUNT_DEF;
  localparam int POOL_SIZE      = 48;
  localparam int PHASE_ITEMS    = 144;
  localparam int PHASES         = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int REPORT_MAX     = 10;

  // unused request code, treated as a miss by the block
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  wb_valid;
    logic [WB_BLOCK_W-1:0] wb_block;
  } slot_reply_t;

  // slot pool shadow and queue of replies still owed by the block
  class slot_pool_scoreboard;
    bit                    occupied [SLOTS];
    bit                    dirty    [SLOTS];
    logic [WB_BLOCK_W-1:0] held     [SLOTS];
    logic [AGE_W-1:0]      age      [SLOTS];
    slot_reply_t           owed_replies[$];
    int                    errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        occupied[i] = 0;
        dirty[i]    = 0;
        held[i]     = '0;
        age[i]      = '0;
      end
      errors = 0;
    endfunction

    // work out the reply to an accepted request and update the shadow pool
    function void note_request(logic [REQ_W-1:0] rq, logic [BLOCK_IN_W-1:0] bn);
      slot_reply_t r;
      int pick;
      int best;
      r.status   = ST_OK;
      r.slot     = '0;
      r.wb_valid = 1'b0;
      r.wb_block = '0;
      pick       = -1;
      if (int'(bn) >= BLOCK_LIMIT) begin
        r.status = ST_OUT_OF_BOUND;
      end else if (rq == REQ_ALLOC) begin
        // age occupied slots, saturating
        for (int i = 0; i < SLOTS; i++) begin
          if (occupied[i] && age[i] != AGE_MAX) age[i] = age[i] + 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (!occupied[i] && pick < 0) pick = i;
        end
        // pool full: evict the oldest, highest index on a tie
        if (pick < 0) begin
          best = 0;
          pick = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (int'(age[i]) >= best) begin
              best = int'(age[i]);
              pick = i;
            end
          end
          if (dirty[pick]) begin
            r.wb_valid = 1'b1;
            r.wb_block = held[pick];
          end
        end
        occupied[pick] = 1;
        dirty[pick]    = 0;
        held[pick]     = bn[WB_BLOCK_W-1:0];
        age[pick]      = '0;
        r.slot         = pick[SLOT_OUT_W-1:0];
      end else if (rq == REQ_LOOKUP || rq == REQ_DIRTY) begin
        // lowest occupied slot holding the block
        for (int i = 0; i < SLOTS; i++) begin
          if (occupied[i] && held[i] == bn[WB_BLOCK_W-1:0] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          r.status = ST_NOT_IN_BUF;
        end else begin
          if (rq == REQ_DIRTY) dirty[pick] = 1;
          r.slot = pick[SLOT_OUT_W-1:0];
        end
      end else begin
        r.status = ST_NOT_IN_BUF;
      end
      owed_replies.push_back(r);
    endfunction

    // compare one reply from the block with the oldest owed reply
    function void check_reply(logic [STATUS_W-1:0] st, logic [SLOT_OUT_W-1:0] sl,
                              logic wv, logic [WB_BLOCK_W-1:0] wb);
      slot_reply_t e;
      if (owed_replies.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected reply: status %0d slot %0d wb_valid %0b wb_block %0d",
                   st, sl, wv, wb);
        return;
      end
      e = owed_replies.pop_front();
      if (st !== e.status || sl !== e.slot || wv !== e.wb_valid || wb !== e.wb_block) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("reply mismatch: expected status %0d slot %0d wb %0b/%0d, got %0d %0d %0b/%0d",
                   e.status, e.slot, e.wb_valid, e.wb_block, st, sl, wv, wb);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [REQ_W-1:0]      req_type;
  logic [BLOCK_IN_W-1:0] block_num;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  writeback_valid;
  logic [WB_BLOCK_W-1:0] writeback_block;

  slot_pool_scoreboard   sb;
  int                    idle_pct;
  int                    stall_pct;
  int                    hold_left;
  int                    quiet_cycles;
  logic [BLOCK_IN_W-1:0] block_pool [POOL_SIZE];

  buffer_pool_oldest_replacement_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .block_num       (block_num),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .slot_index      (slot_index),
    .writeback_valid (writeback_valid),
    .writeback_block (writeback_block)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // accepted items on both channels, and the watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_request(req_type, block_num);
      if (out_valid && !out_stall)
        sb.check_reply(status, slot_index, writeback_valid, writeback_block);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // offer one item, after idle cycles drawn one at a time, and wait until it is taken
  task automatic send_request(input logic [REQ_W-1:0] rq, input logic [BLOCK_IN_W-1:0] bn);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rq;
    block_num <= bn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        idle_pct = 66;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct = 0;
        stall_pct = 66;
      end
      default: begin
        idle_pct = 32;
        stall_pct = 32;
      end
    endcase
  endtask

  // random request: mostly blocks from a small pool so lookups and evictions hit
  task automatic send_random_request();
    int roll;
    logic [BLOCK_IN_W-1:0] bn;
    roll = $urandom_range(0, 99);
    bn   = block_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 45)      send_request(REQ_ALLOC, bn);
    else if (roll < 70) send_request(REQ_LOOKUP, bn);
    else if (roll < 88) send_request(REQ_DIRTY, bn);
    else if (roll < 93) send_request(REQ_UNUSED, bn);
    else send_request(REQ_W'($urandom_range(0, 3)), BLOCK_IN_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    req_type  = '0;
    block_num = '0;
    hold_left = 0;
    set_idling(IDLE_NONE);
    sb = new();
    block_pool[0] = '0;
    block_pool[1] = BLOCK_IN_W'(BLOCK_LIMIT - 1);
    for (int i = 2; i < POOL_SIZE; i++)
      block_pool[i] = BLOCK_IN_W'($urandom_range(0, BLOCK_LIMIT - 1));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: misses on an empty pool, bounds, unused code
    send_request(REQ_LOOKUP, 16'd0);
    send_request(REQ_DIRTY, 16'd0);
    send_request(REQ_UNUSED, 16'd5);
    send_request(REQ_ALLOC, 16'd8192);
    send_request(REQ_ALLOC, 16'hFFFF);
    send_request(REQ_LOOKUP, 16'hE000);
    send_request(REQ_DIRTY, 16'hA000);
    // directed: extremes, duplicate allocate, hits and marks
    send_request(REQ_ALLOC, 16'd0);
    send_request(REQ_ALLOC, 16'd8191);
    send_request(REQ_ALLOC, 16'd8191);
    send_request(REQ_LOOKUP, 16'd8191);
    send_request(REQ_DIRTY, 16'd8191);
    send_request(REQ_DIRTY, 16'd0);
    send_request(REQ_UNUSED, 16'd8191);
    send_request(REQ_LOOKUP, 16'h1555);
    send_request(REQ_DIRTY, 16'h0AAA);
    send_request(REQ_ALLOC, 16'h1555);
    send_request(REQ_LOOKUP, 16'h1555);

    // random phases; one holds the receiver off to back the block up
    for (int ph = 0; ph < PHASES; ph++) begin
      set_idling(idle_mode_t'(ph % 4));
      if (ph == 4) hold_left = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_request();
    end

    // drain
    in_valid <= 1'b0;
    set_idling(IDLE_NONE);
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bpor_pkg.sv
rtl/bpor_front.sv
rtl/bpor_queue.sv
rtl/bpor_back.sv
rtl/buffer_pool_oldest_replacement_unit.sv
sim/buffer_pool_oldest_replacement_unit_tb.sv
